// ----- rtl/biquad_pkg.sv -----
package biquad_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int COEF_WIDTH_DEF   = 18;
	localparam int STATE_WIDTH_DEF  = 24;

	localparam int CFG_INDEX_WIDTH = 3;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_FF_GAIN_0 = 3'd0,
		CFG_FF_GAIN_1 = 3'd1,
		CFG_FF_GAIN_2 = 3'd2,
		CFG_FB_GAIN_1 = 3'd3,
		CFG_FB_GAIN_2 = 3'd4
	} cfg_reg_t;

endpackage

// ----- rtl/biquad_iir_filter.sv -----
// Second-order IIR section, direct form II, fixed point. Samples are signed Q0.15,
// the five coefficients (b0, b1, b2, a1, a2) are signed Q3.14, which the user must
// write through the cfg port while the filter is idle (the block does not enforce
// it); the two delay elements are 24-bit Q8.15 and saturate. Every product is
// rounded to nearest (ties up), and the output saturates to the sample width;
// clipped flags a saturation of the node or of the output. One multiplier does the
// five multiply-accumulates in turn; in_stall stays high until the sequencer returns to
// S_IDLE, so no new sample is taken before the last is through. A result waiting in the
// output register does not block the next sample until its last step.
module biquad_iir_filter
	import biquad_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
	parameter int STATE_WIDTH  = STATE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              cfg_wr_en,
	input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
	input  logic [COEF_WIDTH-1:0]             cfg_data,

	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]    sample_in,

	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]    sample_out,
	output logic                              clipped
);

	localparam int COEF_FRAC = COEF_WIDTH - 4;
	localparam int PROD_W    = COEF_WIDTH + STATE_WIDTH;
	localparam int RND_W     = PROD_W - COEF_FRAC;
	localparam int ACC_W     = ((RND_W > SAMPLE_WIDTH) ? RND_W : SAMPLE_WIDTH) + 2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FB1,
		S_FB2,
		S_NODE,
		S_FF1,
		S_FF0,
		S_DONE
	} state_t;

	state_t state_q;

	logic signed [COEF_WIDTH-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
	logic signed [STATE_WIDTH-1:0]  d1_q, d2_q, w_q;
	logic signed [PROD_W-1:0]       prod_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic                           clip_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
	logic                           clipped_q;

	logic signed [COEF_WIDTH-1:0]   coef_op;
	logic signed [STATE_WIDTH-1:0]  val_op;
	logic signed [PROD_W-1:0]       mul;
	logic [PROD_W-1:0]              prod_rnd;
	logic signed [ACC_W-1:0]        rnd_term;
	logic signed [ACC_W-1:0]        acc_sub;
	logic signed [ACC_W-1:0]        acc_add;
	logic [ACC_W-STATE_WIDTH:0]     w_top;
	logic [ACC_W-SAMPLE_WIDTH:0]    y_top;
	logic                           w_ovf;
	logic                           y_ovf;
	logic signed [STATE_WIDTH-1:0]  w_sat;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;
	logic                           in_accept;
	logic                           out_free;

	assign in_stall   = (state_q != S_IDLE);
	assign in_accept  = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;
	assign out_free   = !out_valid_q || !out_stall;

	// operand select for the shared multiplier
	always_comb begin
		case (state_q)
			S_FB1:   begin coef_op = a1_q; val_op = d1_q; end
			S_FB2:   begin coef_op = a2_q; val_op = d2_q; end
			S_NODE:  begin coef_op = b1_q; val_op = d1_q; end
			S_FF1:   begin coef_op = b2_q; val_op = d2_q; end
			S_FF0:   begin coef_op = b0_q; val_op = w_q;  end
			default: begin coef_op = b0_q; val_op = w_q;  end
		endcase
	end

	assign mul = coef_op * val_op;

	// round half up, then drop the coefficient fraction
	assign prod_rnd = prod_q + (PROD_W'(1) << (COEF_FRAC - 1));
	assign rnd_term = {{(ACC_W-RND_W){prod_rnd[PROD_W-1]}}, prod_rnd[PROD_W-1:COEF_FRAC]};
	assign acc_sub  = acc_q - rnd_term;
	assign acc_add  = acc_q + rnd_term;

	assign w_top = acc_sub[ACC_W-1:STATE_WIDTH-1];
	assign w_ovf = !((&w_top) || !(|w_top));
	assign w_sat = w_ovf ? {acc_sub[ACC_W-1], {(STATE_WIDTH-1){~acc_sub[ACC_W-1]}}}
	                     : acc_sub[STATE_WIDTH-1:0];

	assign y_top = acc_add[ACC_W-1:SAMPLE_WIDTH-1];
	assign y_ovf = !((&y_top) || !(|y_top));
	assign y_sat = y_ovf ? {acc_add[ACC_W-1], {(SAMPLE_WIDTH-1){~acc_add[ACC_W-1]}}}
	                     : acc_add[SAMPLE_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= '0;
			b1_q <= '0;
			b2_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_FF_GAIN_0: b0_q <= cfg_data;
				CFG_FF_GAIN_1: b1_q <= cfg_data;
				CFG_FF_GAIN_2: b2_q <= cfg_data;
				CFG_FB_GAIN_1: a1_q <= cfg_data;
				CFG_FB_GAIN_2: a2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		prod_q <= mul;
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					acc_q <= {{(ACC_W-SAMPLE_WIDTH){sample_in[SAMPLE_WIDTH-1]}}, sample_in};
				end
			end
			S_FB2:  acc_q <= acc_sub;
			S_NODE: begin
				w_q   <= w_sat;
				acc_q <= '0;
			end
			S_FF1:  acc_q <= acc_add;
			S_FF0:  acc_q <= acc_add;
			S_DONE: begin
				if (out_free) begin
					sample_out_q <= y_sat;
					clipped_q    <= clip_q || y_ovf;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			d1_q        <= '0;
			d2_q        <= '0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_FB1;
					end
				end
				S_FB1:  state_q <= S_FB2;
				S_FB2:  state_q <= S_NODE;
				S_NODE: begin
					clip_q  <= w_ovf;
					state_q <= S_FF1;
				end
				S_FF1:  state_q <= S_FF0;
				S_FF0:  state_q <= S_DONE;
				S_DONE: begin
					// hold here until the output register can take the beat
					if (out_free) begin
						d2_q    <= d1_q;
						d1_q    <= w_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_FB1)
		else $error("accepted sample did not start the sequence");

	a_seq_advance: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FB1 |=> state_q == S_FB2)
		else $error("sequencer stalled mid-sample");

	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && !(out_valid_q && out_stall) |=> state_q == S_IDLE && out_valid_q)
		else $error("finished sample not presented");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result appeared without a finished sample");

	a_delays_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_DONE |=> $stable(d1_q) && $stable(d2_q))
		else $error("delay line moved outside the final step");

endmodule
